/* rtl/lct_pkg.sv */
// ----------------------------------------------------------------------------
// lct_pkg
// Shared widths, request kinds and the update bundle of the presence table.
// ----------------------------------------------------------------------------
`default_nettype none

package lct_pkg;

   localparam int ENTRIES = 1024;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int ID_W    = 10;
   localparam int CODE_W  = 32;
   localparam int KIND_W  = 3;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int SLOT_W  = ID_W + 1;

   localparam logic [KIND_W-1:0] KIND_LOGIN  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LOGOUT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;

   localparam logic signed [CODE_W-1:0] CODE_NONE = -32'sd1;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_SLOT = 3'b010,
      PH_EVAL = 3'b100
   } phase_type;

   typedef struct packed {
      logic                     code_we;
      logic                     slot_of_id_we;
      logic [ADDR_W-1:0]        slot_of_id_data;
      logic                     slot_we;
      logic [ADDR_W-1:0]        slot_addr;
      logic [SLOT_W-1:0]        slot_data;
      logic [CNT_W-1:0]         slots_used_in;
      logic [CNT_W-1:0]         active_in;
      logic signed [CODE_W-1:0] code_out;
      logic                     found;
   } update_type;

endpackage

`default_nettype wire

/* rtl/lct_req_if.sv */
// ----------------------------------------------------------------------------
// lct_req_if
// Request channel of the presence table: valid, ready and one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lct_req_if;
   import lct_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [ID_W-1:0]          entry_id;
   logic signed [CODE_W-1:0] code_value;

   modport source (output valid, output kind, output entry_id, output code_value,
                   input ready);
   modport sink   (input valid, input kind, input entry_id, input code_value,
                   output ready);
endinterface

`default_nettype wire

/* rtl/lct_rsp_if.sv */
// ----------------------------------------------------------------------------
// lct_rsp_if
// Response channel of the presence table: valid, ready and one response.
// ----------------------------------------------------------------------------
`default_nettype none

interface lct_rsp_if;
   import lct_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CNT_W-1:0]         online_count;
   logic signed [CODE_W-1:0] code_out;
   logic                     found;

   modport source (output valid, output online_count, output code_out, output found,
                   input ready);
   modport sink   (input valid, input online_count, input code_out, input found,
                   output ready);
endinterface

`default_nettype wire

/* rtl/lct_ram.sv */
// ----------------------------------------------------------------------------
// lct_ram
// Simple dual-port RAM with registered read data, write data forwarded to a
// read of the same address in the same cycle, read data held when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         if (we && (waddr == raddr)) begin
            rdata_ff <= wdata;
         end else begin
            rdata_ff <= mem[raddr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/lct_update.sv */
// ----------------------------------------------------------------------------
// lct_update
// Membership check and read-modify-write decision for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module lct_update (
   input  wire logic [lct_pkg::KIND_W-1:0]        kind,
   input  wire logic [lct_pkg::ID_W-1:0]          entry_id,
   input  wire logic [lct_pkg::ADDR_W-1:0]        slot_idx,
   input  wire logic [lct_pkg::SLOT_W-1:0]        slot_word,
   input  wire logic signed [lct_pkg::CODE_W-1:0] code_rd,
   input  wire logic [lct_pkg::CNT_W-1:0]         slots_used,
   input  wire logic [lct_pkg::CNT_W-1:0]         active,
   output      lct_pkg::update_type               upd
);
   import lct_pkg::*;

   logic in_range;
   logic member;
   logic online;
   logic has_room;

   always_comb begin
      in_range = ({1'b0, entry_id} < (ID_W + 1)'(ENTRIES));
      member   = 1'b0;
      if (in_range && (CNT_W'(slot_idx) < slots_used)
          && (slot_word[SLOT_W-1:1] == entry_id)) begin
         member = 1'b1;
      end
      online   = member && slot_word[0];
      has_room = slots_used < CNT_W'(ENTRIES);

      upd.code_we         = 1'b0;
      upd.slot_of_id_we   = 1'b0;
      upd.slot_of_id_data = slots_used[ADDR_W-1:0];
      upd.slot_we         = 1'b0;
      upd.slot_addr       = slot_idx;
      upd.slot_data       = {entry_id, 1'b1};
      upd.slots_used_in   = slots_used;
      upd.active_in       = active;
      upd.code_out        = CODE_NONE;
      upd.found           = 1'b0;

      unique case (kind)
         KIND_LOGIN: begin
            priority if (online) begin
               upd.code_we = 1'b1;
            end else if (member) begin
               upd.code_we   = 1'b1;
               upd.slot_we   = 1'b1;
               upd.active_in = active + CNT_W'(1);
            end else if (in_range && has_room) begin
               upd.code_we       = 1'b1;
               upd.slot_we       = 1'b1;
               upd.slot_addr     = slots_used[ADDR_W-1:0];
               upd.slot_of_id_we = 1'b1;
               upd.slots_used_in = slots_used + CNT_W'(1);
               upd.active_in     = active + CNT_W'(1);
            end
         end
         KIND_LOGOUT: begin
            if (online) begin
               upd.slot_we   = 1'b1;
               upd.slot_data = {entry_id, 1'b0};
               upd.active_in = active - CNT_W'(1);
            end
         end
         KIND_CLOSE: begin
            upd.slots_used_in = '0;
            upd.active_in     = '0;
         end
         KIND_COUNT: begin
         end
         KIND_QUERY: begin
            if (online) begin
               upd.code_out = code_rd;
               upd.found    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/lazy_clear_presence_table.sv */
// ----------------------------------------------------------------------------
// lazy_clear_presence_table
// Keyed presence table with a constant-time clear, kept as a sparse set in
// three RAMs: slot of each id, id and online bit of each slot, code of each id.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    kind, entry_id, code_value
//   rsp      out  valid/ready    online_count, code_out, found
//
// A request passes through the SLOT and EVAL phases: the accepting edge
// reads the slot and the code of the id, the next edge reads the slot word,
// and write-back, once the response output is free, writes the update back
// and registers the response. A new request is accepted in the write-back
// cycle, so the first reads of one request overlap the write-back of the
// last; RAM reads forward a write to the same address. Reset clears the
// phase, the counts and the output valid and holds off requests; the RAMs
// need no clearing. A stalled response holds write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module lazy_clear_presence_table (
   input  wire logic clock,
   input  wire logic reset,
   lct_req_if.sink   req,
   lct_rsp_if.source rsp
);
   import lct_pkg::*;

   phase_type                phase_ff, phase_in;
   logic [KIND_W-1:0]        kind_ff;
   logic [ID_W-1:0]          id_ff;
   logic signed [CODE_W-1:0] code_ff;
   logic [CNT_W-1:0]         used_ff, used_in;
   logic [CNT_W-1:0]         active_ff, active_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]         rsp_count_ff;
   logic signed [CODE_W-1:0] rsp_code_ff;
   logic                     rsp_found_ff;

   logic                     out_free;
   logic                     eval_go;
   logic                     accept;
   logic [ADDR_W-1:0]        slot_idx;
   logic [SLOT_W-1:0]        slot_word;
   logic [CODE_W-1:0]        code_rd;
   update_type               upd;
   logic                     slot_we;
   logic                     soi_we;
   logic                     code_we;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign eval_go   = (phase_ff == PH_EVAL) && out_free;
   assign req.ready = !reset && ((phase_ff == PH_IDLE) || eval_go);
   assign accept    = req.valid && req.ready;

   assign slot_we = eval_go && upd.slot_we;
   assign soi_we  = eval_go && upd.slot_of_id_we;
   assign code_we = eval_go && upd.code_we;

   lct_ram #(.WIDTH(ADDR_W), .DEPTH(ENTRIES)) u_slot_of_id (
      .clock (clock),
      .we    (soi_we),
      .waddr (id_ff[ADDR_W-1:0]),
      .wdata (upd.slot_of_id_data),
      .re    (accept),
      .raddr (req.entry_id[ADDR_W-1:0]),
      .rdata (slot_idx)
   );

   lct_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_slot_store (
      .clock (clock),
      .we    (slot_we),
      .waddr (upd.slot_addr),
      .wdata (upd.slot_data),
      .re    (phase_ff == PH_SLOT),
      .raddr (slot_idx),
      .rdata (slot_word)
   );

   lct_ram #(.WIDTH(CODE_W), .DEPTH(ENTRIES)) u_code_store (
      .clock (clock),
      .we    (code_we),
      .waddr (id_ff[ADDR_W-1:0]),
      .wdata (code_ff),
      .re    (accept),
      .raddr (req.entry_id[ADDR_W-1:0]),
      .rdata (code_rd)
   );

   lct_update u_update (
      .kind       (kind_ff),
      .entry_id   (id_ff),
      .slot_idx   (slot_idx),
      .slot_word  (slot_word),
      .code_rd    (signed'(code_rd)),
      .slots_used (used_ff),
      .active     (active_ff),
      .upd        (upd)
   );

   always_comb begin
      unique case (phase_ff)
         PH_IDLE: phase_in = accept ? PH_SLOT : PH_IDLE;
         PH_SLOT: phase_in = PH_EVAL;
         PH_EVAL: begin
            if (eval_go) begin
               phase_in = accept ? PH_SLOT : PH_IDLE;
            end else begin
               phase_in = PH_EVAL;
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      used_in   = eval_go ? upd.slots_used_in : used_ff;
      active_in = eval_go ? upd.active_in : active_ff;

      priority if (eval_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         used_ff      <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         used_ff      <= used_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req.kind;
         id_ff   <= req.entry_id;
         code_ff <= req.code_value;
      end
      if (eval_go) begin
         rsp_count_ff <= upd.active_in;
         rsp_code_ff  <= upd.code_out;
         rsp_found_ff <= upd.found;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.online_count = rsp_count_ff;
   assign rsp.code_out     = rsp_code_ff;
   assign rsp.found        = rsp_found_ff;

   a_active_le_used: assert property (@(posedge clock) disable iff (reset)
      active_ff <= used_ff)
      else $error("online count exceeds slots in use");

   a_no_accept_in_slot: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SLOT) |-> !accept)
      else $error("request accepted while slot word is read");

   a_slot_then_eval: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SLOT) |=> (phase_ff == PH_EVAL))
      else $error("slot read not followed by write-back");

   a_eval_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      eval_go |=> rsp_valid_ff)
      else $error("write-back did not raise response valid");

endmodule

`default_nettype wire
